@@ rtl/co2_alarm_level_controller_macros.svh @@
// Assertion macros for the CO2 alarm level controller.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef CO2_ALARM_LEVEL_CONTROLLER_MACROS_SVH
`define CO2_ALARM_LEVEL_CONTROLLER_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define CO2ALC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequent is checked after the antecedent, through a non-overlapping implication and a further delay.
`define CO2ALC_ASSERT_TWO(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
    else $error(msg);

`endif

@@ rtl/co2alc_pkg.sv @@
// Shared types and constants for the CO2 alarm level controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package co2alc_pkg;

  // Alarm levels, same codes as the alarm_level field.
  typedef enum logic [1:0] {
    LVL_STOP     = 2'd0,
    LVL_PRE      = 2'd1,
    LVL_CONT     = 2'd2,
    LVL_NOSENSOR = 2'd3
  } level_t;

  // Register map: index taken from paddr[4:2].
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 5;
  localparam logic [REG_IDX_W-1:0] REG_ALARM_THR    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRE_THR      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DELAY_TICKS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_ON     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_OFF    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SENSOR_PRES  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_EN     = 3'd6;

  // Register reset values.
  localparam logic [15:0] RST_ALARM_THR   = 16'd1500;
  localparam logic [15:0] RST_PRE_THR     = 16'd1000;
  localparam logic [7:0]  RST_DELAY_TICKS = 8'd5;
  localparam logic [7:0]  RST_BLINK_ON    = 8'd2;
  localparam logic [7:0]  RST_BLINK_OFF   = 8'd2;
  localparam logic        RST_SENSOR_PRES = 1'b1;
  localparam logic        RST_DRIVE_EN    = 1'b1;

  // Queue between classifier and state update.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration seen by both halves of the block.
  typedef struct packed {
    logic [15:0] alarm_threshold;
    logic [15:0] pre_alarm_threshold;
    logic [7:0]  alarm_delay_ticks;
    logic [7:0]  blink_on_ticks;
    logic [7:0]  blink_off_ticks;
    logic        sensor_present;
    logic        drive_enable;
  } cfg_t;

  // Queue status towards the front and back.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

@@ rtl/co2_alarm_level_controller.sv @@
// CO2 alarm level controller: one tick item in, one result out.
// Each input transfer is written into the queue, and its result into the output register.
// Throughput: one item per cycle while out_stall is low, through classifier, two-entry
// queue and state register. Reset (rst, synchronous, active high) clears queue, alarm
// state and output valid, and loads the register defaults.
`timescale 1ns / 1ps

`include "co2_alarm_level_controller_macros.svh"

module co2_alarm_level_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [co2alc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   co2_ppm,
  input  logic                          reading_missing,
  input  logic                          warming_up,
  input  logic                          manual_mode,
  input  logic [1:0]                    manual_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    alarm_level,
  output logic                          alarm_active,
  output logic                          alarm_pin
);
  import co2alc_pkg::*;

  cfg_t                 cfg;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 push;
  logic                 pop;
  level_t               front_level;
  level_t               head_level;
  q_status_t            q_status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_threshold     <= RST_ALARM_THR;
      cfg.pre_alarm_threshold <= RST_PRE_THR;
      cfg.alarm_delay_ticks   <= RST_DELAY_TICKS;
      cfg.blink_on_ticks      <= RST_BLINK_ON;
      cfg.blink_off_ticks     <= RST_BLINK_OFF;
      cfg.sensor_present      <= RST_SENSOR_PRES;
      cfg.drive_enable        <= RST_DRIVE_EN;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ALARM_THR:   cfg.alarm_threshold     <= pwdata[15:0];
        REG_PRE_THR:     cfg.pre_alarm_threshold <= pwdata[15:0];
        REG_DELAY_TICKS: cfg.alarm_delay_ticks   <= pwdata[7:0];
        REG_BLINK_ON:    cfg.blink_on_ticks      <= pwdata[7:0];
        REG_BLINK_OFF:   cfg.blink_off_ticks     <= pwdata[7:0];
        REG_SENSOR_PRES: cfg.sensor_present      <= pwdata[0];
        REG_DRIVE_EN:    cfg.drive_enable        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_ALARM_THR:   prdata = {16'd0, cfg.alarm_threshold};
      REG_PRE_THR:     prdata = {16'd0, cfg.pre_alarm_threshold};
      REG_DELAY_TICKS: prdata = {24'd0, cfg.alarm_delay_ticks};
      REG_BLINK_ON:    prdata = {24'd0, cfg.blink_on_ticks};
      REG_BLINK_OFF:   prdata = {24'd0, cfg.blink_off_ticks};
      REG_SENSOR_PRES: prdata = {31'd0, cfg.sensor_present};
      REG_DRIVE_EN:    prdata = {31'd0, cfg.drive_enable};
      default:         prdata = 32'd0;
    endcase
  end

  co2alc_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .co2_ppm         (co2_ppm),
    .reading_missing (reading_missing),
    .warming_up      (warming_up),
    .manual_mode     (manual_mode),
    .manual_level    (manual_level),
    .cfg             (cfg),
    .q_full          (q_status.full),
    .push            (push),
    .level           (front_level)
  );

  co2alc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_level (front_level),
    .pop        (pop),
    .head_level (head_level),
    .status     (q_status)
  );

  co2alc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_status.valid),
    .head_level   (head_level),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alarm_level  (alarm_level),
    .alarm_active (alarm_active),
    .alarm_pin    (alarm_pin)
  );

  // A transfer into an empty block passes through the queue and reaches the output register.
  `CO2ALC_ASSERT_TWO(a_empty_latency, in_valid && !in_stall && !q_status.valid && !out_valid, out_valid, "transfer into empty block did not reach the output")
  // The stop level always leaves the alarm off.
  `CO2ALC_ASSERT_SAME(a_stop_off, out_valid && alarm_level == LVL_STOP, !alarm_active && !alarm_pin, "stop level with alarm on")
  // The drive pin is never high while the logical alarm is off.
  `CO2ALC_ASSERT_SAME(a_pin_implies_active, out_valid && alarm_pin, alarm_active, "drive pin high with alarm off")

endmodule

@@ rtl/co2alc_front.sv @@
// Front end: accepts tick items and sorts each into an alarm level.
// Depends on co2alc_pkg.
`timescale 1ns / 1ps

module co2alc_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        co2_ppm,
  input  logic               reading_missing,
  input  logic               warming_up,
  input  logic               manual_mode,
  input  logic [1:0]         manual_level,
  input  co2alc_pkg::cfg_t   cfg,
  input  logic               q_full,
  output logic               push,
  output co2alc_pkg::level_t level
);
  import co2alc_pkg::*;

  level_t level_auto;

  // A transfer is taken whenever the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classification, in priority order.
  always_comb begin
    priority if (!cfg.sensor_present || warming_up) begin
      level_auto = LVL_STOP;
    end else if (reading_missing) begin
      level_auto = LVL_NOSENSOR;
    end else if (co2_ppm >= cfg.alarm_threshold) begin
      level_auto = LVL_CONT;
    end else if (co2_ppm >= cfg.pre_alarm_threshold) begin
      level_auto = LVL_PRE;
    end else begin
      level_auto = LVL_STOP;
    end
  end

  assign level = manual_mode ? level_t'(manual_level) : level_auto;

endmodule

@@ rtl/co2alc_queue.sv @@
// Short level queue decoupling the classifier from the state update.
// Depends on co2alc_pkg.
`timescale 1ns / 1ps

module co2alc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  co2alc_pkg::level_t      push_level,
  input  logic                    pop,
  output co2alc_pkg::level_t      head_level,
  output co2alc_pkg::q_status_t   status
);
  import co2alc_pkg::*;

  level_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign status.valid = (count != '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_level   = entries[rd_ptr];

  // Entry storage; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_level;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/co2alc_back.sv @@
// Back end: applies each level to the delay, blink and alarm state and
// holds the result in an output register. Depends on co2alc_pkg.
`timescale 1ns / 1ps

module co2alc_back (
  input  logic               clk,
  input  logic               rst,
  input  co2alc_pkg::cfg_t   cfg,
  input  logic               q_valid,
  input  co2alc_pkg::level_t head_level,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         alarm_level,
  output logic               alarm_active,
  output logic               alarm_pin
);
  import co2alc_pkg::*;

  logic [7:0] delay_count, delay_count_next;
  logic [7:0] blink_count, blink_count_next;
  logic       status_on,   status_on_next;
  logic       pin_level,   pin_level_next;
  logic [7:0] blink_inc;

  // Take the next level whenever the output register is free or being emptied.
  assign pop       = q_valid && (!out_valid || !out_stall);
  assign blink_inc = blink_count + 8'd1;

  // State update for one tick.
  always_comb begin
    delay_count_next = delay_count;
    blink_count_next = blink_count;
    status_on_next   = status_on;
    pin_level_next   = pin_level;
    unique case (head_level)
      LVL_CONT, LVL_NOSENSOR: begin
        if (delay_count != 8'd0) begin
          delay_count_next = delay_count - 8'd1;
        end else begin
          status_on_next = 1'b1;
          pin_level_next = cfg.drive_enable ? 1'b1 : pin_level;
        end
      end
      LVL_PRE: begin
        if (delay_count != 8'd0) begin
          delay_count_next = delay_count - 8'd1;
        end else begin
          blink_count_next = blink_inc;
          if (status_on) begin
            if (blink_inc >= cfg.blink_on_ticks) begin
              status_on_next   = 1'b0;
              pin_level_next   = 1'b0;
              blink_count_next = 8'd0;
            end
          end else if (blink_inc >= cfg.blink_off_ticks) begin
            status_on_next   = 1'b1;
            pin_level_next   = cfg.drive_enable ? 1'b1 : pin_level;
            blink_count_next = 8'd0;
          end
        end
      end
      LVL_STOP: begin
        status_on_next   = 1'b0;
        pin_level_next   = 1'b0;
        delay_count_next = cfg.alarm_delay_ticks;
      end
    endcase
  end

  // Alarm state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_count <= 8'd0;
      blink_count <= 8'd0;
      status_on   <= 1'b0;
      pin_level   <= 1'b0;
    end else if (pop) begin
      delay_count <= delay_count_next;
      blink_count <= blink_count_next;
      status_on   <= status_on_next;
      pin_level   <= pin_level_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      alarm_level  <= head_level;
      alarm_active <= status_on_next;
      alarm_pin    <= pin_level_next;
    end
  end

endmodule

@@ dv/co2_alarm_level_controller_test.sv @@
// Self-checking testbench for the CO2 alarm level controller.
// Depends on co2alc_pkg and co2_alarm_level_controller; it predicts every result in place
// and checks the register port, the level sorting, the delay and the blink timing.
`timescale 1ns / 1ps

module co2_alarm_level_controller_test;
  import co2alc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 8;

  // One alarm tick as offered to the block.
  typedef struct {
    logic [15:0] ppm;
    logic        missing;
    logic        warming;
    logic        manual;
    level_t      mlevel;
  } tick_t;

  // One result as the block should return it.
  typedef struct {
    level_t level;
    logic   active;
    logic   pin;
  } alarm_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic [15:0]          co2_ppm;
  logic                 reading_missing;
  logic                 warming_up;
  logic                 manual_mode;
  logic [1:0]           manual_level;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           alarm_level;
  logic                 alarm_active;
  logic                 alarm_pin;

  // Predicted state of the controller and its register settings.
  cfg_t                 cfg;
  logic [7:0]           delay_cnt;
  logic [7:0]           blink_cnt;
  logic                 status_on;
  logic                 pin_on;

  alarm_result_t        expected_alarms[$];
  alarm_result_t        want;
  int                   mismatch_count = 0;
  int                   quiet_cycles = 0;
  int                   hold_left = 0;
  bit                   hold_request = 1'b0;
  bit                   no_gaps = 1'b0;

  co2_alarm_level_controller u_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .co2_ppm         (co2_ppm),
    .reading_missing (reading_missing),
    .warming_up      (warming_up),
    .manual_mode     (manual_mode),
    .manual_level    (manual_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .alarm_level     (alarm_level),
    .alarm_active    (alarm_active),
    .alarm_pin       (alarm_pin)
  );

  always #4 clk = ~clk;

  // Works out the level for one tick and advances the predicted alarm state.
  function automatic alarm_result_t predict_alarm(input tick_t t);
    level_t        lvl;
    alarm_result_t r;
    if (t.manual) lvl = t.mlevel;
    else if (!cfg.sensor_present || t.warming) lvl = LVL_STOP;
    else if (t.missing) lvl = LVL_NOSENSOR;
    else if (t.ppm >= cfg.alarm_threshold) lvl = LVL_CONT;
    else if (t.ppm >= cfg.pre_alarm_threshold) lvl = LVL_PRE;
    else lvl = LVL_STOP;

    case (lvl)
      LVL_CONT, LVL_NOSENSOR: begin
        if (delay_cnt != 8'd0) begin
          delay_cnt = delay_cnt - 8'd1;
        end else begin
          status_on = 1'b1;
          if (cfg.drive_enable) pin_on = 1'b1;
        end
      end
      LVL_PRE: begin
        if (delay_cnt != 8'd0) begin
          delay_cnt = delay_cnt - 8'd1;
        end else begin
          // The blink counter survives level changes and wraps at 256.
          blink_cnt = blink_cnt + 8'd1;
          if (status_on) begin
            if (blink_cnt >= cfg.blink_on_ticks) begin
              status_on = 1'b0;
              pin_on    = 1'b0;
              blink_cnt = 8'd0;
            end
          end else if (blink_cnt >= cfg.blink_off_ticks) begin
            status_on = 1'b1;
            if (cfg.drive_enable) pin_on = 1'b1;
            blink_cnt = 8'd0;
          end
        end
      end
      default: begin
        status_on = 1'b0;
        pin_on    = 1'b0;
        delay_cnt = cfg.alarm_delay_ticks;
      end
    endcase

    r.level  = lvl;
    r.active = status_on;
    r.pin    = pin_on;
    return r;
  endfunction

  function automatic tick_t mk_tick(input logic [15:0] ppm, input logic missing,
                                    input logic warming, input logic manual,
                                    input level_t lvl);
    tick_t t;
    t.ppm     = ppm;
    t.missing = missing;
    t.warming = warming;
    t.manual  = manual;
    t.mlevel  = lvl;
    return t;
  endfunction

  // Random tick that mostly lands on the wanted level under the present settings.
  function automatic tick_t random_tick(input level_t goal);
    tick_t t;
    int    lo_thr;
    t.ppm     = 16'($urandom);
    t.missing = 1'($urandom_range(0, 1));
    t.warming = 1'($urandom_range(0, 1));
    t.manual  = 1'($urandom_range(0, 1));
    t.mlevel  = level_t'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) return t;

    t.missing = 1'b0;
    t.warming = 1'b0;
    t.manual  = 1'b0;
    lo_thr = (cfg.alarm_threshold < cfg.pre_alarm_threshold) ?
             int'(cfg.alarm_threshold) : int'(cfg.pre_alarm_threshold);
    case (goal)
      LVL_CONT: t.ppm = 16'($urandom_range(65535, int'(cfg.alarm_threshold)));
      LVL_PRE: begin
        if (cfg.pre_alarm_threshold < cfg.alarm_threshold) begin
          t.ppm = 16'($urandom_range(int'(cfg.alarm_threshold) - 1,
                                     int'(cfg.pre_alarm_threshold)));
        end else begin
          t.manual = 1'b1;
          t.mlevel = LVL_PRE;
        end
      end
      LVL_NOSENSOR: t.missing = 1'b1;
      default: begin
        if (lo_thr > 0) t.ppm = 16'($urandom_range(lo_thr - 1, 0));
        else t.warming = 1'b1;
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      t.manual = 1'b1;
      t.mlevel = goal;
    end
    return t;
  endfunction

  // Offers one tick, holds it until the transfer and records its expected result.
  task automatic send_tick(input tick_t t);
    if (!no_gaps && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    co2_ppm         <= t.ppm;
    reading_missing <= t.missing;
    warming_up      <= t.warming;
    manual_mode     <= t.manual;
    manual_level    <= t.mlevel;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_alarms.push_back(predict_alarm(t));
  endtask

  // Stops offering ticks and waits until every expected result has come back.
  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    while (expected_alarms.size() != 0) @(posedge clk);
  endtask

  // One register port transfer: setup, access until pready, then a return to idle.
  task automatic reg_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] reg_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_ALARM_THR:   return 32'(cfg.alarm_threshold);
      REG_PRE_THR:     return 32'(cfg.pre_alarm_threshold);
      REG_DELAY_TICKS: return 32'(cfg.alarm_delay_ticks);
      REG_BLINK_ON:    return 32'(cfg.blink_on_ticks);
      REG_BLINK_OFF:   return 32'(cfg.blink_off_ticks);
      REG_SENSOR_PRES: return 32'(cfg.sensor_present);
      REG_DRIVE_EN:    return 32'(cfg.drive_enable);
      default:         return 32'd0;
    endcase
  endfunction

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
    logic [31:0] rdata;
    reg_access(1'b0, idx, 32'd0, rdata);
    if (rdata !== reg_value(idx)) begin
      $display("%0t: register %0d read expected %0h got %0h", $time, idx,
               reg_value(idx), rdata);
      mismatch_count++;
    end
  endtask

  // Writes a register once the block is idle, mirrors it and reads it back.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] rdata;
    drain;
    reg_access(1'b1, idx, value, rdata);
    case (idx)
      REG_ALARM_THR:   cfg.alarm_threshold     = value[15:0];
      REG_PRE_THR:     cfg.pre_alarm_threshold = value[15:0];
      REG_DELAY_TICKS: cfg.alarm_delay_ticks   = value[7:0];
      REG_BLINK_ON:    cfg.blink_on_ticks      = value[7:0];
      REG_BLINK_OFF:   cfg.blink_off_ticks     = value[7:0];
      REG_SENSOR_PRES: cfg.sensor_present      = value[0];
      REG_DRIVE_EN:    cfg.drive_enable        = value[0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_ALARM_THR,   32'(c.alarm_threshold));
    write_reg(REG_PRE_THR,     32'(c.pre_alarm_threshold));
    write_reg(REG_DELAY_TICKS, 32'(c.alarm_delay_ticks));
    write_reg(REG_BLINK_ON,    32'(c.blink_on_ticks));
    write_reg(REG_BLINK_OFF,   32'(c.blink_off_ticks));
    write_reg(REG_SENSOR_PRES, 32'(c.sensor_present));
    write_reg(REG_DRIVE_EN,    32'(c.drive_enable));
  endtask

  // Runs of ticks aimed at one level, each of random length.
  task automatic run_random(input int count);
    int     sent;
    int     run_len;
    level_t goal;
    sent = 0;
    while (sent < count) begin
      goal    = level_t'($urandom_range(0, 3));
      run_len = $urandom_range(1, 24);
      for (int i = 0; i < run_len && sent < count; i++) begin
        send_tick(random_tick(goal));
        sent++;
      end
    end
  endtask

  task automatic test_register_defaults;
    for (int i = REG_ALARM_THR; i <= REG_DRIVE_EN; i++) check_reg(REG_IDX_W'(i));
  endtask

  // Threshold edges, full-scale readings, missing reading, warming and manual levels.
  task automatic test_classification;
    send_tick(mk_tick(16'd0,     1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd999,   1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd1000,  1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd1499,  1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd1500,  1'b0, 1'b0, 1'b0, LVL_STOP));
    repeat (3) send_tick(mk_tick(16'hFFFF, 1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd0,     1'b1, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'hFFFF,  1'b1, 1'b1, 1'b0, LVL_NOSENSOR));
    send_tick(mk_tick(16'd0,     1'b0, 1'b0, 1'b1, LVL_NOSENSOR));
    send_tick(mk_tick(16'hFFFF,  1'b1, 1'b1, 1'b1, LVL_STOP));
    send_tick(mk_tick(16'd1200,  1'b0, 1'b1, 1'b1, LVL_PRE));
    send_tick(mk_tick(16'd1200,  1'b0, 1'b0, 1'b1, LVL_CONT));
  endtask

  // Sensor absent, drive disabled with zero blink counts, and crossed thresholds.
  task automatic test_special_settings;
    write_reg(REG_SENSOR_PRES, 32'd0);
    send_tick(mk_tick(16'hFFFF, 1'b1, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd1200, 1'b0, 1'b0, 1'b0, LVL_STOP));
    write_reg(REG_SENSOR_PRES, 32'd1);

    write_reg(REG_DELAY_TICKS, 32'd0);
    write_reg(REG_BLINK_ON,    32'd0);
    write_reg(REG_BLINK_OFF,   32'd0);
    write_reg(REG_DRIVE_EN,    32'd0);
    repeat (4) send_tick(mk_tick(16'd1200, 1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'hFFFF, 1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd0,    1'b0, 1'b0, 1'b0, LVL_STOP));
    write_reg(REG_DRIVE_EN, 32'd1);
    repeat (2) send_tick(mk_tick(16'd1200, 1'b0, 1'b0, 1'b0, LVL_STOP));

    // Continuous threshold below the pre-alarm one: continuous wins.
    write_reg(REG_ALARM_THR, 32'd800);
    write_reg(REG_PRE_THR,   32'd2000);
    send_tick(mk_tick(16'd1000, 1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd2500, 1'b0, 1'b0, 1'b0, LVL_STOP));
    send_tick(mk_tick(16'd500,  1'b0, 1'b0, 1'b0, LVL_STOP));
  endtask

  // Several settings, first all-zero values with sensor and drive on, then all-maximum values with drive off.
  task automatic test_random_settings;
    cfg_t c;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        c = '0;
        c.sensor_present = 1'b1;
        c.drive_enable   = 1'b1;
      end else if (phase == 1) begin
        c = '1;
        c.drive_enable = 1'b0;
      end else begin
        c.pre_alarm_threshold = 16'($urandom_range(0, 4000));
        c.alarm_threshold     = ($urandom_range(0, 4) == 0) ?
                                16'($urandom_range(0, 4000)) :
                                16'(int'(c.pre_alarm_threshold) + $urandom_range(0, 2000));
        c.alarm_delay_ticks = 8'($urandom_range(0, 8));
        c.blink_on_ticks    = 8'($urandom_range(0, 6));
        c.blink_off_ticks   = 8'($urandom_range(0, 6));
        c.sensor_present    = ($urandom_range(0, 7) != 0);
        c.drive_enable      = ($urandom_range(0, 3) != 0);
      end
      apply_settings(c);
      run_random(130);
    end
  endtask

  // A long stretch with neither side idling.
  task automatic test_steady_flow;
    drain;
    no_gaps = 1'b1;
    run_random(120);
    drain;
    no_gaps = 1'b0;
  endtask

  // The receiver holds off while ticks keep coming, so the block must stall its input.
  task automatic test_output_hold;
    hold_request = 1'b1;
    run_random(60);
  endtask

  // Receiving side: checks each result transfer and decides the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_alarms.size() == 0) begin
        $display("%0t: result with none expected: level %0d active %0b pin %0b",
                 $time, alarm_level, alarm_active, alarm_pin);
        mismatch_count++;
      end else begin
        want = expected_alarms.pop_front();
        if (alarm_level !== want.level) begin
          $display("%0t: alarm_level expected %0d got %0d", $time, want.level, alarm_level);
          mismatch_count++;
        end
        if (alarm_active !== want.active) begin
          $display("%0t: alarm_active expected %0b got %0b", $time, want.active,
                   alarm_active);
          mismatch_count++;
        end
        if (alarm_pin !== want.pin) begin
          $display("%0t: alarm_pin expected %0b got %0b", $time, want.pin, alarm_pin);
          mismatch_count++;
        end
      end
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(0, 99) < 25);
    end
  end

  // Ends the run if nothing moves on either channel or the register port for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    co2_ppm         = '0;
    reading_missing = 1'b0;
    warming_up      = 1'b0;
    manual_mode     = 1'b0;
    manual_level    = '0;

    cfg.alarm_threshold     = RST_ALARM_THR;
    cfg.pre_alarm_threshold = RST_PRE_THR;
    cfg.alarm_delay_ticks   = RST_DELAY_TICKS;
    cfg.blink_on_ticks      = RST_BLINK_ON;
    cfg.blink_off_ticks     = RST_BLINK_OFF;
    cfg.sensor_present      = RST_SENSOR_PRES;
    cfg.drive_enable        = RST_DRIVE_EN;
    delay_cnt = 8'd0;
    blink_cnt = 8'd0;
    status_on = 1'b0;
    pin_on    = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults;
    test_classification;
    test_special_settings;
    test_random_settings;
    test_steady_flow;
    test_output_hold;

    drain;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
